FILE: design/class_aware_box_suppression_assert.svh
// Assertion macros used by the box suppression checker.
// Plain text macros only; no other dependencies.
`ifndef CLASS_AWARE_BOX_SUPPRESSION_ASSERT_SVH
`define CLASS_AWARE_BOX_SUPPRESSION_ASSERT_SVH

// next-cycle implication, disabled while reset is low
`define CABS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cabs assertion failed");

// next-cycle implication that also holds through reset
`define CABS_ASSERT_NEXT_ALL(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("cabs assertion failed");

`endif

FILE: design/cabs_pkg.sv
// Shared types and constants for the class aware box suppression block.
// No dependencies.
`timescale 1ns / 1ps
package cabs_pkg;

    localparam int MAX_BOXES = 64;
    localparam int IDX_W     = $clog2(MAX_BOXES);
    localparam int CNT_W     = $clog2(MAX_BOXES + 1);

    // overlap arithmetic widths
    localparam int INTER_W = 32;          // 16 x 16 unsigned
    localparam int AREA_W  = 34;          // 17 x 17 signed
    localparam int UNI_W   = 36;          // sum of two areas minus overlap
    localparam int PROD_W  = 16 + UNI_W - 1;

    localparam logic [15:0] IOU_LIMIT_RESET = 16'd29491;
    localparam logic        REG_IOU_LIMIT   = 1'b0;   // paddr[2] of the limit register

    typedef struct packed {
        logic signed [15:0] x_left;
        logic signed [15:0] y_top;
        logic signed [15:0] x_right;
        logic signed [15:0] y_bottom;
        logic        [15:0] score;
        logic        [7:0]  class_index;
    } t_box;

    localparam int BOX_W = $bits(t_box);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_PUSH  = 4'b1000
    } t_state;

    typedef struct packed {
        logic load;
        logic scan_init;
        logic issue;
        logic take;
        logic push;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic idx_last;
        logic pipe_busy;
        logic found;
        logic have_a;
        logic out_free;
    } t_dp_status;

endpackage

FILE: design/class_aware_box_suppression.sv
// Top level of the per-class greedy box suppression block.
// Depends on cabs_pkg, cabs_ctrl, cabs_dp (and cabs_ram below it).
//
//  channel | handshake          | word
//  --------+--------------------+------------------------------------------
//  in      | i_valid / o_ready  | corners, score, class, last_box
//  out     | o_valid / i_ready  | kept corners, score, class, last, overflow
//  cfg     | APB psel / penable | iou_limit at byte address 0
//
// Loading accepts boxes back to back while idle. After the last box, one
// ranking pass runs, then one pass per surviving box, each pass streaming
// the box store through the overlap pipe.
// A full output word stalls the sequencer until it is taken.
// Reset is synchronous; the box store needs no clearing pass.
`timescale 1ns / 1ps
module class_aware_box_suppression (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_x_left,
    input  logic signed [15:0] i_y_top,
    input  logic signed [15:0] i_x_right,
    input  logic signed [15:0] i_y_bottom,
    input  logic [15:0]        i_score,
    input  logic [7:0]         i_class_index,
    input  logic               i_last_box,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_kept_x_left,
    output logic signed [15:0] o_kept_y_top,
    output logic signed [15:0] o_kept_x_right,
    output logic signed [15:0] o_kept_y_bottom,
    output logic [15:0]        o_kept_score,
    output logic [7:0]         o_kept_class,
    output logic               o_last_result,
    output logic               o_overflow,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import cabs_pkg::*;

    logic [15:0] r_iou_limit;
    logic        w_accept;
    t_box        w_in_box;
    t_box        w_out_box;
    t_dp_cmd     w_cmd;
    t_dp_status  w_status;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iou_limit <= IOU_LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_IOU_LIMIT)) begin
            r_iou_limit <= pwdata[15:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_IOU_LIMIT) ? {16'h0000, r_iou_limit} : 32'h0000_0000;

    assign w_accept = i_valid & o_ready;

    assign w_in_box.x_left      = i_x_left;
    assign w_in_box.y_top       = i_y_top;
    assign w_in_box.x_right     = i_x_right;
    assign w_in_box.y_bottom    = i_y_bottom;
    assign w_in_box.score       = i_score;
    assign w_in_box.class_index = i_class_index;

    cabs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_last    (i_last_box),
        .i_status  (w_status),
        .o_cmd     (w_cmd),
        .o_in_ready(o_ready)
    );

    cabs_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_box         (w_in_box),
        .i_iou_limit   (r_iou_limit),
        .i_out_ready   (i_ready),
        .o_out_valid   (o_valid),
        .o_out_box     (w_out_box),
        .o_out_last    (o_last_result),
        .o_out_overflow(o_overflow)
    );

    assign o_kept_x_left   = w_out_box.x_left;
    assign o_kept_y_top    = w_out_box.y_top;
    assign o_kept_x_right  = w_out_box.x_right;
    assign o_kept_y_bottom = w_out_box.y_bottom;
    assign o_kept_score    = w_out_box.score;
    assign o_kept_class    = w_out_box.class_index;

endmodule

FILE: design/cabs_ram.sv
// Generic single write port RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
module cabs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/cabs_ctrl.sv
// Sequencer for loading, scan passes and result hand-off.
// Depends on cabs_pkg.
`timescale 1ns / 1ps
module cabs_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_last,
    input  cabs_pkg::t_dp_status i_status,
    output cabs_pkg::t_dp_cmd    o_cmd,
    output logic                 o_in_ready
);
    import cabs_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    o_cmd.load = 1'b1;
                    if (i_last) begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_status.idx_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (!i_status.have_a) begin
                    // first pass only ranks; always finds a box
                    o_cmd.take      = 1'b1;
                    o_cmd.scan_init = 1'b1;
                    n_state         = ST_SCAN;
                end else if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    if (i_status.found) begin
                        o_cmd.take      = 1'b1;
                        o_cmd.scan_init = 1'b1;
                        n_state         = ST_SCAN;
                    end else begin
                        o_cmd.finish = 1'b1;
                        n_state      = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

FILE: design/cabs_dp.sv
// Datapath: box store, pipelined overlap scan, keep/alive masks, output word.
// Depends on cabs_pkg and cabs_ram.
`timescale 1ns / 1ps
module cabs_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cabs_pkg::t_dp_cmd    i_cmd,
    output cabs_pkg::t_dp_status o_status,
    input  cabs_pkg::t_box       i_box,
    input  logic [15:0]          i_iou_limit,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output cabs_pkg::t_box       o_out_box,
    output logic                 o_out_last,
    output logic                 o_out_overflow
);
    import cabs_pkg::*;

    // set bookkeeping
    logic [CNT_W-1:0]     r_count;
    logic                 r_dropped;
    logic [MAX_BOXES-1:0] r_alive;
    logic [MAX_BOXES-1:0] r_done;
    logic [IDX_W-1:0]     r_idx;
    logic                 w_full;
    logic                 w_we;

    // current kept box and best candidate of the running pass
    logic                     r_have_a;
    t_box                     r_a;
    logic signed [AREA_W-1:0] r_a_area;
    logic                     r_found;
    t_box                     r_cand;
    logic signed [AREA_W-1:0] r_cand_area;
    logic [IDX_W-1:0]         r_cand_idx;

    // scan pipeline
    logic [BOX_W-1:0] w_rdata;
    t_box             w_b;
    logic             r_p0_v, r_p1_v, r_p2_v, r_p3_v, r_p4_v;
    logic [IDX_W-1:0] r_p0_idx, r_p1_idx, r_p2_idx, r_p3_idx, r_p4_idx;
    t_box             r_p1_box, r_p2_box, r_p3_box, r_p4_box;
    logic             r_p1_elig, r_p2_elig, r_p3_elig, r_p4_elig;
    logic             r_p1_clsm, r_p2_clsm, r_p3_clsm, r_p4_clsm;
    logic [15:0]      r_p1_ow, r_p1_oh;
    logic signed [16:0] r_p1_dxb, r_p1_dyb;
    logic [INTER_W-1:0] r_p2_inter, r_p3_inter, r_p4_inter;
    logic signed [AREA_W-1:0] r_p2_areab, r_p3_areab, r_p4_areab;
    logic signed [UNI_W-1:0]  r_p3_uni;
    logic             r_p4_upos;
    logic [PROD_W-1:0] r_p4_prod;

    logic signed [15:0] w_ixl, w_ixr, w_iyt, w_iyb;
    logic signed [16:0] w_dw, w_dh;
    logic               w_sup, w_better;

    // output word
    logic r_out_valid;
    t_box r_out_box;
    logic r_out_last;
    logic r_out_ovf;

    assign w_full = (r_count == CNT_W'(MAX_BOXES));
    assign w_we   = i_cmd.load & ~w_full;

    cabs_ram #(
        .WIDTH(BOX_W),
        .DEPTH(MAX_BOXES)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_count[IDX_W-1:0]),
        .i_wdata(i_box),
        .i_raddr(r_idx),
        .o_rdata(w_rdata)
    );

    assign w_b = w_rdata;

    // intersection extents against the kept box
    assign w_ixl = (r_a.x_left   > w_b.x_left)   ? r_a.x_left   : w_b.x_left;
    assign w_ixr = (r_a.x_right  < w_b.x_right)  ? r_a.x_right  : w_b.x_right;
    assign w_iyt = (r_a.y_top    > w_b.y_top)    ? r_a.y_top    : w_b.y_top;
    assign w_iyb = (r_a.y_bottom < w_b.y_bottom) ? r_a.y_bottom : w_b.y_bottom;
    assign w_dw  = 17'(w_ixr) - 17'(w_ixl);
    assign w_dh  = 17'(w_iyb) - 17'(w_iyt);

    // last stage: suppress, else compete for the next kept box
    assign w_sup = r_have_a & r_p4_elig & r_p4_clsm & r_p4_upos &
                   (PROD_W'({r_p4_inter, 16'h0000}) > r_p4_prod);
    assign w_better = r_p4_v & r_p4_elig & ~w_sup &
                      (~r_found | (r_p4_box.score > r_cand.score));

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_alive     <= '0;
            r_done      <= '0;
            r_idx       <= '0;
            r_have_a    <= 1'b0;
            r_found     <= 1'b0;
            r_p0_v      <= 1'b0;
            r_p1_v      <= 1'b0;
            r_p2_v      <= 1'b0;
            r_p3_v      <= 1'b0;
            r_p4_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (w_full) begin
                    r_dropped <= 1'b1;
                end else begin
                    r_alive[r_count[IDX_W-1:0]] <= 1'b1;
                    r_count <= r_count + 1'b1;
                end
            end

            r_p0_v <= i_cmd.issue;
            r_p1_v <= r_p0_v;
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
            r_p4_v <= r_p3_v;

            if (i_cmd.issue) begin
                r_idx <= r_idx + 1'b1;
            end

            if (r_p4_v & w_sup) begin
                r_alive[r_p4_idx] <= 1'b0;
            end
            if (w_better) begin
                r_found <= 1'b1;
            end

            if (i_cmd.take) begin
                r_have_a            <= 1'b1;
                r_done[r_cand_idx]  <= 1'b1;
            end
            if (i_cmd.scan_init) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end

            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.finish) begin
                r_count   <= '0;
                r_dropped <= 1'b0;
                r_alive   <= '0;
                r_done    <= '0;
                r_have_a  <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        // stage 1: extents and side lengths
        r_p0_idx  <= r_idx;
        r_p1_idx  <= r_p0_idx;
        r_p1_box  <= w_b;
        r_p1_elig <= r_alive[r_p0_idx] & ~r_done[r_p0_idx];
        r_p1_clsm <= (w_b.class_index == r_a.class_index);
        r_p1_ow   <= w_dw[16] ? 16'h0000 : w_dw[15:0];
        r_p1_oh   <= w_dh[16] ? 16'h0000 : w_dh[15:0];
        r_p1_dxb  <= 17'(w_b.x_right)  - 17'(w_b.x_left);
        r_p1_dyb  <= 17'(w_b.y_bottom) - 17'(w_b.y_top);

        // stage 2: overlap and own area
        r_p2_idx   <= r_p1_idx;
        r_p2_box   <= r_p1_box;
        r_p2_elig  <= r_p1_elig;
        r_p2_clsm  <= r_p1_clsm;
        r_p2_inter <= r_p1_ow * r_p1_oh;
        r_p2_areab <= r_p1_dxb * r_p1_dyb;

        // stage 3: union
        r_p3_idx   <= r_p2_idx;
        r_p3_box   <= r_p2_box;
        r_p3_elig  <= r_p2_elig;
        r_p3_clsm  <= r_p2_clsm;
        r_p3_inter <= r_p2_inter;
        r_p3_areab <= r_p2_areab;
        r_p3_uni   <= UNI_W'(r_a_area) + UNI_W'(r_p2_areab) -
                      $signed({{(UNI_W-INTER_W){1'b0}}, r_p2_inter});

        // stage 4: threshold times union
        r_p4_idx   <= r_p3_idx;
        r_p4_box   <= r_p3_box;
        r_p4_elig  <= r_p3_elig;
        r_p4_clsm  <= r_p3_clsm;
        r_p4_inter <= r_p3_inter;
        r_p4_areab <= r_p3_areab;
        r_p4_upos  <= (r_p3_uni > 0);
        r_p4_prod  <= i_iou_limit * r_p3_uni[UNI_W-2:0];

        if (w_better) begin
            r_cand      <= r_p4_box;
            r_cand_area <= r_p4_areab;
            r_cand_idx  <= r_p4_idx;
        end
        if (i_cmd.take) begin
            r_a      <= r_cand;
            r_a_area <= r_cand_area;
        end
        if (i_cmd.push) begin
            r_out_box  <= r_a;
            r_out_last <= ~r_found;
            r_out_ovf  <= r_dropped;
        end
    end

    assign o_status.idx_last  = (CNT_W'(r_idx) == r_count - 1'b1);
    assign o_status.pipe_busy = r_p0_v | r_p1_v | r_p2_v | r_p3_v | r_p4_v;
    assign o_status.found     = r_found;
    assign o_status.have_a    = r_have_a;
    assign o_status.out_free  = ~r_out_valid | i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_out_box      = r_out_box;
    assign o_out_last     = r_out_last;
    assign o_out_overflow = r_out_ovf;

endmodule

FILE: design/cabs_checker.sv
// Port-level checks for class_aware_box_suppression, bound to the top level.
// Depends on class_aware_box_suppression_assert.svh.
`timescale 1ns / 1ps
`include "class_aware_box_suppression_assert.svh"
module cabs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        i_last_box,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_kept_score,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);

    // a waiting result word holds
    `CABS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `CABS_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_valid && !i_ready, $stable(o_kept_score))
    // reset empties the output word
    `CABS_ASSERT_NEXT_ALL(a_rst_out, i_clk, !i_rst_n, !o_valid)
    // a closing box starts processing, so intake stops
    `CABS_ASSERT_NEXT(a_last_stops_in, i_clk, i_rst_n, i_valid && o_ready && i_last_box, !o_ready)
    // a written threshold reads back
    `CABS_ASSERT_NEXT(a_cfg_readback, i_clk, i_rst_n, psel && penable && pwrite && !paddr[2], paddr[2] || (prdata[15:0] == $past(pwdata[15:0])))

endmodule

bind class_aware_box_suppression cabs_checker u_cabs_checker (.*);

FILE: tb/sv/cabs_nms_checker.sv
// Checker for the class aware box suppression block: watches the input, output
// and configuration channels, predicts the kept boxes with greedy per-class
// suppression and compares. Depends on cabs_pkg.
`timescale 1ns / 1ps
module cabs_nms_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_ready,
    input  logic signed [15:0] i_x_left,
    input  logic signed [15:0] i_y_top,
    input  logic signed [15:0] i_x_right,
    input  logic signed [15:0] i_y_bottom,
    input  logic [15:0]        i_score,
    input  logic [7:0]         i_class_index,
    input  logic               i_last_box,
    input  logic               o_valid,
    input  logic               i_ready,
    input  logic signed [15:0] o_kept_x_left,
    input  logic signed [15:0] o_kept_y_top,
    input  logic signed [15:0] o_kept_x_right,
    input  logic signed [15:0] o_kept_y_bottom,
    input  logic [15:0]        o_kept_score,
    input  logic [7:0]         o_kept_class,
    input  logic               o_last_result,
    input  logic               o_overflow,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_kept_seen
);
    import cabs_pkg::*;

    typedef struct packed {
        t_box box;
        logic last;
        logic ovf;
    } t_kept;

    t_box        set_boxes[$];
    logic        set_dropped;
    logic [15:0] iou_limit_copy;
    t_kept       kept_queue[$];
    int          fail_count;
    int          kept_seen;

    assign o_fail_count = fail_count;
    assign o_pending    = kept_queue.size();
    assign o_kept_seen  = kept_seen;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // true when box b overlaps kept box a above the threshold
    function automatic bit too_close(t_box b, t_box a, logic [15:0] lim);
        longint ow, oh, inter, uni;
        ow = (a.x_right < b.x_right ? a.x_right : b.x_right)
           - (a.x_left > b.x_left ? a.x_left : b.x_left);
        oh = (a.y_bottom < b.y_bottom ? a.y_bottom : b.y_bottom)
           - (a.y_top > b.y_top ? a.y_top : b.y_top);
        if (ow < 0) ow = 0;
        if (oh < 0) oh = 0;
        inter = ow * oh;
        uni = (longint'(b.x_right) - longint'(b.x_left)) *
              (longint'(b.y_bottom) - longint'(b.y_top))
            + (longint'(a.x_right) - longint'(a.x_left)) *
              (longint'(a.y_bottom) - longint'(a.y_top)) - inter;
        if (uni <= 0) return 0;
        return inter * 65536 > longint'(lim) * uni;
    endfunction

    // rank the set, suppress, queue the survivors
    task automatic predict_survivors();
        int  rank[$];
        bit  alive[$];
        int  j, n, nkept, emitted;
        t_kept k;
        n = set_boxes.size();
        for (int i = 0; i < n; i++) begin
            j = 0;
            while (j < rank.size() && set_boxes[rank[j]].score >= set_boxes[i].score) j++;
            rank.insert(j, i);
            alive.insert(alive.size(), 1'b1);
        end
        for (int i = 0; i < n; i++) begin
            if (!alive[rank[i]]) continue;
            for (int m = i + 1; m < n; m++) begin
                if (!alive[rank[m]]) continue;
                if (set_boxes[rank[m]].class_index != set_boxes[rank[i]].class_index) continue;
                if (too_close(set_boxes[rank[m]], set_boxes[rank[i]], iou_limit_copy))
                    alive[rank[m]] = 1'b0;
            end
        end
        nkept = 0;
        foreach (alive[i]) if (alive[i]) nkept++;
        emitted = 0;
        for (int i = 0; i < n; i++) begin
            if (!alive[rank[i]]) continue;
            emitted++;
            k.box  = set_boxes[rank[i]];
            k.last = (emitted == nkept);
            k.ovf  = set_dropped;
            kept_queue.insert(kept_queue.size(), k);
        end
    endtask

    always @(posedge i_clk) begin
        t_box  b;
        t_kept want;
        if (!i_rst_n) begin
            set_boxes.delete();
            kept_queue.delete();
            set_dropped     = 1'b0;
            iou_limit_copy <= IOU_LIMIT_RESET;
            fail_count      = 0;
            kept_seen      <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_IOU_LIMIT)
                iou_limit_copy <= pwdata[15:0];
            // compare an accepted kept word with the oldest prediction
            if (o_valid && i_ready) begin
                kept_seen <= kept_seen + 1;
                if (kept_queue.size() == 0) begin
                    report_mismatch("unexpected kept word, score", o_kept_score, -1);
                end else begin
                    want = kept_queue.pop_front();
                    if (o_kept_x_left != want.box.x_left)
                        report_mismatch("x_left", o_kept_x_left, want.box.x_left);
                    if (o_kept_y_top != want.box.y_top)
                        report_mismatch("y_top", o_kept_y_top, want.box.y_top);
                    if (o_kept_x_right != want.box.x_right)
                        report_mismatch("x_right", o_kept_x_right, want.box.x_right);
                    if (o_kept_y_bottom != want.box.y_bottom)
                        report_mismatch("y_bottom", o_kept_y_bottom, want.box.y_bottom);
                    if (o_kept_score != want.box.score)
                        report_mismatch("score", o_kept_score, want.box.score);
                    if (o_kept_class != want.box.class_index)
                        report_mismatch("class", o_kept_class, want.box.class_index);
                    if (o_last_result != want.last)
                        report_mismatch("last_result", o_last_result, want.last);
                    if (o_overflow != want.ovf)
                        report_mismatch("overflow", o_overflow, want.ovf);
                end
            end
            // load an accepted box word
            if (i_valid && o_ready) begin
                b = '{i_x_left, i_y_top, i_x_right, i_y_bottom, i_score, i_class_index};
                if (set_boxes.size() < MAX_BOXES) set_boxes.insert(set_boxes.size(), b);
                else set_dropped = 1'b1;
                if (i_last_box) begin
                    predict_survivors();
                    set_boxes.delete();
                    set_dropped = 1'b0;
                end
            end
        end
    end
endmodule

FILE: tb/sv/tb_class_aware_box_suppression.sv
// Testbench top for class_aware_box_suppression: drives box sets and the
// threshold register, and gives the verdict. Depends on cabs_pkg, the block
// and cabs_nms_checker.
`timescale 1ns / 1ps
module tb_class_aware_box_suppression;
    import cabs_pkg::*;

    logic               i_clk, i_rst_n;
    logic               i_valid, o_ready, o_valid, i_ready;
    logic signed [15:0] i_x_left, i_y_top, i_x_right, i_y_bottom;
    logic [15:0]        i_score;
    logic [7:0]         i_class_index;
    logic               i_last_box;
    logic signed [15:0] o_kept_x_left, o_kept_y_top, o_kept_x_right, o_kept_y_bottom;
    logic [15:0]        o_kept_score;
    logic [7:0]         o_kept_class;
    logic               o_last_result, o_overflow;
    logic               psel, penable, pwrite, pready;
    logic [2:0]         paddr;
    logic [31:0]        pwdata, prdata;
    int                 fail_count, pending, kept_seen;
    int                 boxes_sent, sets_sent;
    bit                 calm;   // no idling near the end

    class_aware_box_suppression dut (.*);
    cabs_nms_checker chk (.*, .o_fail_count(fail_count), .o_pending(pending),
                          .o_kept_seen(kept_seen));

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // output side back-pressure in bursts
    initial begin
        int gap;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 10);
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
        end
    end

    task automatic write_limit(input logic [15:0] lim);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {REG_IOU_LIMIT, 2'b00}; pwdata <= {16'h0, lim};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic send_box(input t_box b, input logic last);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        {i_x_left, i_y_top, i_x_right, i_y_bottom, i_score, i_class_index} <= b;
        i_last_box <= last;
        do @(posedge i_clk); while (!o_ready);
        boxes_sent++;
        if (last) sets_sent++;
    endtask

    // wait for every kept word, then let the block settle
    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // boxes clustered near a few centers so that suppression happens often
    function automatic t_box random_box(input int cls_span);
        t_box b;
        int cx, cy, w, h;
        if ($urandom_range(0, 9) == 0) begin
            b = t_box'({$urandom, $urandom, $urandom});
        end else begin
            cx = $urandom_range(0, 3) * 400 - 600 + $urandom_range(0, 60);
            cy = $urandom_range(0, 3) * 400 - 600 + $urandom_range(0, 60);
            w = $urandom_range(20, 300);
            h = $urandom_range(20, 300);
            b.x_left = 16'(cx - w); b.x_right = 16'(cx + w);
            b.y_top = 16'(cy - h);  b.y_bottom = 16'(cy + h);
            b.score = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3) * 16384)
                                                  : 16'($urandom);
            b.class_index = 8'($urandom_range(0, cls_span));
        end
        return b;
    endfunction

    task automatic random_set(input int n, input int cls_span);
        for (int i = 0; i < n; i++) send_box(random_box(cls_span), i == n - 1);
    endtask

    initial begin
        t_box b;
        logic [15:0] limits[4];
        limits = '{16'd0, 16'hFFFF, 16'd32768, 16'd20000};
        i_rst_n = 1'b0; i_valid = 1'b0; i_last_box = 1'b0;
        {i_x_left, i_y_top, i_x_right, i_y_bottom, i_score, i_class_index} = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        calm = 1'b0; boxes_sent = 0; sets_sent = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset threshold, equal-score ties, extremes, one-box set
        b = '{16'sd0, 16'sd0, 16'sd160, 16'sd160, 16'd1000, 8'd3};
        send_box(b, 1'b0);
        send_box(b, 1'b0);                                  // identical, tie
        b.class_index = 8'd4; send_box(b, 1'b0);            // other class
        send_box('{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767,
                   16'hFFFF, 8'hFF}, 1'b0);
        send_box('{16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768,
                   16'h0000, 8'hFF}, 1'b0);                 // inverted corners
        send_box('{16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'd7, 8'h00}, 1'b0);  // zero area
        send_box('{16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'd7, 8'h00}, 1'b1);
        send_box('{16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'h8000, 8'h80}, 1'b1);
        drain();

        // threshold extremes and mid values, each with a few small sets
        foreach (limits[k]) begin
            write_limit(limits[k]);
            repeat (3) random_set($urandom_range(2, 8), 2);
            drain();
        end

        // overflow: more than capacity boxes in one set
        write_limit(16'd29491);
        random_set(MAX_BOXES + 3, 1);
        drain();

        // random sets with random thresholds
        while (boxes_sent < 200) begin
            if ($urandom_range(0, 3) == 0) begin
                drain();
                write_limit(16'($urandom));
            end
            if (boxes_sent > 170) calm = 1'b1;
            random_set($urandom_range(1, 8), $urandom_range(0, 3));
        end
        drain();

        $display("Sent %0d boxes in %0d sets, checked %0d kept boxes.",
                 boxes_sent, sets_sent, kept_seen);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+design
design/cabs_pkg.sv
design/cabs_ram.sv
design/cabs_ctrl.sv
design/cabs_dp.sv
design/class_aware_box_suppression.sv
design/cabs_checker.sv
tb/sv/cabs_nms_checker.sv
tb/sv/tb_class_aware_box_suppression.sv
